### rtl/fijb_pkg.sv
// shared types and constants for the frame indexed jitter buffer
package fijb_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int FRAME_W = 16;
  localparam int ANGLE_W = 8;
  localparam int SPEED_W = 8;
  localparam int ACTION_W = 2;
  localparam int KIND_W = 2;

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAKE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

  localparam logic [ANGLE_W-1:0] HELD_ANGLE_RESET = 8'd128;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SPEED_W-1:0] speed;
    logic [ANGLE_W-1:0] angle;
  } rec_t;

  typedef enum logic [2:0] {
    ST_EXACT = 3'd0,
    ST_PREV = 3'd1,
    ST_HELD = 3'd2,
    ST_PUT_OK = 3'd3,
    ST_PUT_DROP = 3'd4
  } status_t;

endpackage

### rtl/fijb_store.sv
// record memory: one write port, one read port, registered read data
module fijb_store import fijb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rec_t                     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rec_t                     rd_data
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/frame_indexed_jitter_buffer.sv
// top level of the frame indexed jitter buffer
//
// A circular buffer of control records (angle, speed, action) covering a run
// of consecutive 16-bit frame numbers that wrap. A transaction is accepted
// when start is high and busy is low; busy is high for the following cycle
// while the record memory is read or written and the pointers move, and in
// the cycle after that done is high for exactly one cycle with the result on
// out_angle, out_speed, out_action and status. A new transaction may be
// accepted at the edge that ends the done cycle, but none while busy is high,
// since the single access to the record memory has registered read data.
// The receiver cannot stall: a result must be taken in its done cycle. A
// put appends only when its frame follows the last buffered frame and the
// buffer is not full (an empty buffer takes any frame); a take pops up to
// and including the requested frame, and a miss empties the buffer and
// falls back to the previous frame's record or the held record. A find
// looks up without changing anything. There is no clearing pass; reset is
// immediate.
module frame_indexed_jitter_buffer import fijb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [FRAME_W-1:0]  req_frame,
  input  logic [ANGLE_W-1:0]  angle,
  input  logic [SPEED_W-1:0]  speed,
  input  logic [ACTION_W-1:0] action,
  output logic                done,
  output logic [ANGLE_W-1:0]  out_angle,
  output logic [SPEED_W-1:0]  out_speed,
  output logic [ACTION_W-1:0] out_action,
  output logic [2:0]          status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // where the returned record comes from in the done cycle
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_HELD
  } src_t;

  // slot of the entry a given offset past the head, modulo the depth
  function automatic logic [PTR_W-1:0] slot_at(logic [PTR_W-1:0] base,
                                               logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // buffer state
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [FRAME_W-1:0] first_frame;
  rec_t               held;

  // captured transaction
  logic [KIND_W-1:0]  kind_q;
  logic [FRAME_W-1:0] frame_q;
  rec_t               rec_q;

  // result staging
  status_t            status_q;
  src_t               src_q;
  logic               take_q;

  // memory access
  logic               mem_we;
  logic               mem_re;
  logic [PTR_W-1:0]   wr_slot;
  logic [PTR_W-1:0]   rd_slot;
  rec_t               rd_data;
  rec_t               rec_out;

  // lookup decode during the busy cycle
  logic               accept;
  logic [FRAME_W-1:0] off;
  logic [CNT_W-1:0]   off_c;
  logic [CNT_W-1:0]   off_inc;
  logic [CNT_W-1:0]   pop_n;
  logic [PTR_W-1:0]   head_pop;
  logic               hit;
  logic               prev;
  logic               is_put;
  logic               is_take;
  logic               put_ok;

  assign accept = start && !busy;

  always_comb begin
    off     = frame_q - first_frame;
    hit     = off < FRAME_W'(count);
    // a miss can still find the previous frame only as the last entry
    prev    = (count != '0) && (off == FRAME_W'(count));
    is_put  = kind_q == KIND_PUT;
    is_take = kind_q == KIND_TAKE;
    // empty buffer starts a new run at any frame
    put_ok  = (count == '0) ||
              (((first_frame + FRAME_W'(count)) == frame_q) &&
               (count < CNT_W'(DEPTH)));
    off_c   = off[CNT_W-1:0];
    off_inc = off_c + CNT_W'(1);
    pop_n   = hit ? off_inc : count;
    head_pop = slot_at(head, pop_n);
    wr_slot = slot_at(head, count);
    rd_slot = slot_at(head, hit ? off_c : (count - CNT_W'(1)));
    mem_we  = busy && is_put && put_ok;
    mem_re  = busy && !is_put && (hit || prev);
  end

  fijb_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(wr_slot),
    .wr_data(rec_q),
    .rd_en  (mem_re),
    .rd_addr(rd_slot),
    .rd_data(rd_data)
  );

  // transaction capture, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= kind;
      frame_q <= req_frame;
      rec_q   <= '{action: action, speed: speed, angle: angle};
    end
  end

  // result payload staging
  always_ff @(posedge clk) begin
    if (busy) begin
      if (is_put) begin
        status_q <= put_ok ? ST_PUT_OK : ST_PUT_DROP;
        src_q    <= SRC_ZERO;
      end else begin
        status_q <= hit ? ST_EXACT : (prev ? ST_PREV : ST_HELD);
        src_q    <= (hit || prev) ? SRC_MEM : SRC_HELD;
      end
    end
  end

  // control and buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      take_q      <= 1'b0;
      head        <= '0;
      count       <= '0;
      first_frame <= '0;
      held        <= '{action: '0, speed: '0, angle: HELD_ANGLE_RESET};
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        take_q <= !is_put && is_take;
        if (is_put) begin
          if (put_ok) begin
            count <= count + CNT_W'(1);
            if (count == '0) begin
              first_frame <= frame_q;
            end
          end
        end else if (is_take) begin
          // pop through the requested frame, or empty on a miss
          head        <= head_pop;
          count       <= hit ? (count - off_inc) : '0;
          first_frame <= first_frame + FRAME_W'(pop_n);
        end
      end
      // held record follows every take once the read data is back
      if (done && take_q) begin
        held <= rec_out;
      end
    end
  end

  always_comb begin
    case (src_q)
      SRC_MEM:  rec_out = rd_data;
      SRC_HELD: rec_out = held;
      default:  rec_out = '0;
    endcase
  end

  assign out_angle  = rec_out.angle;
  assign out_speed  = rec_out.speed;
  assign out_action = rec_out.action;
  assign status     = status_q;

endmodule

### rtl/fijb_checker.sv
// port level checks for the frame indexed jitter buffer, bound to the top level
module fijb_checker import fijb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [KIND_W-1:0]   kind,
  input logic [FRAME_W-1:0]  req_frame,
  input logic [ANGLE_W-1:0]  angle,
  input logic [SPEED_W-1:0]  speed,
  input logic [ACTION_W-1:0] action,
  input logic                done,
  input logic [ANGLE_W-1:0]  out_angle,
  input logic [SPEED_W-1:0]  out_speed,
  input logic [ACTION_W-1:0] out_action,
  input logic [2:0]          status
);

  // an accepted transaction occupies the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // every busy cycle is followed by its result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("busy cycle not followed by a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // one result per transaction
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // put results carry an empty record
  a_put_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_PUT_OK || status == ST_PUT_DROP) |->
      (out_angle == '0) && (out_speed == '0) && (out_action == '0))
    else $error("put result carries a record");

endmodule

bind frame_indexed_jitter_buffer fijb_checker u_fijb_checker (.*);

### test/tb_frame_indexed_jitter_buffer.sv
// testbench for the frame indexed jitter buffer: directed table, then random transactions
`timescale 1ns / 100ps

module tb_frame_indexed_jitter_buffer;
  import fijb_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_PCT = 22;
  localparam int SETTLE_CYCLES = 8;
  // kind three behaves as a find
  localparam logic [KIND_W-1:0] KIND_FIND_ALT = 2'd3;

  // one row of the directed table; reps > 1 walks frame and angle upwards
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [FRAME_W-1:0]  frame;
    logic [ANGLE_W-1:0]  angle;
    logic [SPEED_W-1:0]  speed;
    logic [ACTION_W-1:0] action;
    logic [4:0]          reps;
    logic                by_hand;
    status_t             want_status;
    rec_t                want_rec;
  } step_t;

  typedef struct packed {
    rec_t    rec;
    status_t st;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [KIND_W-1:0] kind = KIND_PUT;
  logic [FRAME_W-1:0] req_frame = '0;
  logic [ANGLE_W-1:0] angle = '0;
  logic [SPEED_W-1:0] speed = '0;
  logic [ACTION_W-1:0] action = '0;
  logic busy;
  logic done;
  logic [ANGLE_W-1:0] out_angle;
  logic [SPEED_W-1:0] out_speed;
  logic [ACTION_W-1:0] out_action;
  logic [2:0] status;

  frame_indexed_jitter_buffer #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .req_frame(req_frame),
    .angle(angle),
    .speed(speed),
    .action(action),
    .done(done),
    .out_angle(out_angle),
    .out_speed(out_speed),
    .out_action(out_action),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("FAIL frame_indexed_jitter_buffer");
    $finish;
  end

  // shadow copy of the buffer state
  rec_t               shadow_store [DEPTH];
  int                 shadow_head;
  int                 shadow_fill;
  logic [FRAME_W-1:0] shadow_first;
  rec_t               shadow_held;

  reply_t awaited_replies [$];
  int     mismatch_count = 0;
  bit     gaps_on;
  step_t  directed_steps [14];

  // works out the reply to one transaction and moves the shadow state on
  task automatic buffer_reply(input logic [KIND_W-1:0] k, input logic [FRAME_W-1:0] f,
                              input rec_t put_rec, output reply_t r);
    logic [FRAME_W-1:0] off;
    logic ok;
    logic taking;
    r = '0;
    if (k == KIND_PUT) begin
      if (shadow_fill == 0) begin
        shadow_first = f;
        ok = 1'b1;
      end else begin
        ok = (16'(shadow_first + shadow_fill) == f) && (shadow_fill < DEPTH);
      end
      if (ok) begin
        shadow_store[(shadow_head + shadow_fill) % DEPTH] = put_rec;
        shadow_fill++;
      end
      r.st = ok ? ST_PUT_OK : ST_PUT_DROP;
    end else begin
      off = f - shadow_first;
      taking = (k == KIND_TAKE);
      if (int'(off) < shadow_fill) begin
        // hit: pop up to and including the requested frame
        r.rec = shadow_store[(shadow_head + int'(off)) % DEPTH];
        r.st = ST_EXACT;
        if (taking) begin
          shadow_head = (shadow_head + int'(off) + 1) % DEPTH;
          shadow_fill = shadow_fill - int'(off) - 1;
          shadow_first = 16'(shadow_first + off + 1);
          shadow_held = r.rec;
        end
      end else begin
        // miss: the previous frame can only be the newest entry
        if (shadow_fill > 0 && int'(off) == shadow_fill) begin
          r.rec = shadow_store[(shadow_head + shadow_fill - 1) % DEPTH];
          r.st = ST_PREV;
        end else begin
          r.rec = shadow_held;
          r.st = ST_HELD;
        end
        if (taking) begin
          shadow_head = (shadow_head + shadow_fill) % DEPTH;
          shadow_first = 16'(shadow_first + shadow_fill);
          shadow_fill = 0;
          shadow_held = r.rec;
        end
      end
    end
  endtask

  // presents one transaction, with random gaps ahead of it when gaps are on, and records its reply
  task automatic issue(input logic [KIND_W-1:0] k, input logic [FRAME_W-1:0] f,
                       input rec_t rec, input logic by_hand, input reply_t typed);
    reply_t predicted;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    kind <= k;
    req_frame <= f;
    angle <= rec.angle;
    speed <= rec.speed;
    action <= rec.action;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    buffer_reply(k, f, rec, predicted);
    awaited_replies.push_back(by_hand ? typed : predicted);
  endtask

  // sender holds off until every outstanding reply has come back
  task automatic drain;
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // random transaction, mostly well formed around the buffered run
  task automatic pick_item(input logic put_only, output logic [KIND_W-1:0] k,
                           output logic [FRAME_W-1:0] f, output rec_t rec);
    int roll;
    logic [FRAME_W-1:0] near;
    roll = put_only ? 0 : $urandom_range(0, 99);
    near = 16'(shadow_first + $urandom_range(0, shadow_fill + 1));
    rec = rec_t'(18'($urandom));
    if (roll < 45) begin
      k = KIND_PUT;
      f = 16'(shadow_first + shadow_fill);
    end else if (roll < 50) begin
      k = KIND_PUT;
      f = 16'($urandom);
    end else if (roll < 70) begin
      k = KIND_TAKE;
      f = near;
    end else if (roll < 77) begin
      k = KIND_TAKE;
      f = 16'($urandom);
    end else if (roll < 90) begin
      k = KIND_FIND;
      f = near;
    end else if (roll < 95) begin
      k = KIND_FIND;
      f = 16'($urandom);
    end else begin
      k = KIND_FIND_ALT;
      f = near;
    end
  endtask

  // reply checker: done marks a reply that must be taken in that cycle
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with nothing outstanding (status %0d)", $time, status);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_angle !== want.rec.angle) begin
          $display("%0t: out_angle expected %0d actual %0d", $time, want.rec.angle, out_angle);
          mismatch_count++;
        end
        if (out_speed !== want.rec.speed) begin
          $display("%0t: out_speed expected %0d actual %0d", $time, want.rec.speed, out_speed);
          mismatch_count++;
        end
        if (out_action !== want.rec.action) begin
          $display("%0t: out_action expected %0d actual %0d", $time, want.rec.action,
                   out_action);
          mismatch_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] k;
    logic [FRAME_W-1:0] f;
    rec_t rec;
    reply_t typed;
    int burst;
    int sent;

    shadow_head = 0;
    shadow_fill = 0;
    shadow_first = '0;
    shadow_held = '{action: '0, speed: '0, angle: HELD_ANGLE_RESET};
    gaps_on = 1'b1;

    // kind, frame, angle, speed, action, reps, by hand, status, record
    directed_steps = '{
      // empty buffer: find and take both fall back to the reset held record
      '{KIND_FIND, 16'h0000, 8'h00, 8'h00, 2'd0, 5'd1, 1'b1, ST_HELD,
        '{2'd0, 8'h00, HELD_ANGLE_RESET}},
      '{KIND_TAKE, 16'hFFFF, 8'h00, 8'h00, 2'd0, 5'd1, 1'b1, ST_HELD,
        '{2'd0, 8'h00, HELD_ANGLE_RESET}},
      // empty buffer takes any frame as its first
      '{KIND_PUT, 16'hFFF2, 8'hFF, 8'hFF, 2'd3, 5'd1, 1'b1, ST_PUT_OK, '0},
      // frame does not continue the run
      '{KIND_PUT, 16'h0005, 8'h11, 8'h22, 2'd1, 5'd1, 1'b1, ST_PUT_DROP, '0},
      // fill to the brim across the frame wrap
      '{KIND_PUT, 16'hFFF3, 8'h10, 8'hC0, 2'd2, 5'd15, 1'b0, ST_PUT_OK, '0},
      // full buffer drops a contiguous frame
      '{KIND_PUT, 16'h0002, 8'h33, 8'h44, 2'd1, 5'd1, 1'b1, ST_PUT_DROP, '0},
      // find one past the newest entry gives the previous frame
      '{KIND_FIND, 16'h0002, 8'h00, 8'h00, 2'd0, 5'd1, 1'b0, ST_PREV, '0},
      // kind three looks up like a find
      '{KIND_FIND_ALT, 16'hFFF2, 8'h00, 8'h00, 2'd0, 5'd1, 1'b1, ST_EXACT,
        '{2'd3, 8'hFF, 8'hFF}},
      // take pops the three oldest entries
      '{KIND_TAKE, 16'hFFF4, 8'h00, 8'h00, 2'd0, 5'd1, 1'b0, ST_EXACT, '0},
      // find far away returns the held record and changes nothing
      '{KIND_FIND, 16'h8000, 8'h00, 8'h00, 2'd0, 5'd1, 1'b0, ST_HELD, '0},
      // take of the next frame empties the buffer with the previous record
      '{KIND_TAKE, 16'h0002, 8'h00, 8'h00, 2'd0, 5'd1, 1'b0, ST_PREV, '0},
      '{KIND_TAKE, 16'h0002, 8'h00, 8'h00, 2'd0, 5'd1, 1'b0, ST_HELD, '0},
      '{KIND_PUT, 16'h0000, 8'h00, 8'h00, 2'd0, 5'd1, 1'b1, ST_PUT_OK, '0},
      '{KIND_TAKE, 16'h0000, 8'h00, 8'h00, 2'd0, 5'd1, 1'b1, ST_EXACT, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_steps[i]) begin
      for (int j = 0; j < int'(directed_steps[i].reps); j++) begin
        rec.angle = 8'(directed_steps[i].angle + j);
        rec.speed = directed_steps[i].speed ^ 8'(j);
        rec.action = directed_steps[i].action;
        typed.rec = directed_steps[i].want_rec;
        typed.st = directed_steps[i].want_status;
        issue(directed_steps[i].kind, 16'(directed_steps[i].frame + j), rec,
              directed_steps[i].by_hand, typed);
      end
    end
    drain();

    // random part, with now and then a burst of contiguous puts to reach full
    sent = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      // a long stretch with a sender that never idles
      gaps_on = !(sent >= 500 && sent < 800);
      if (sent == 1000) drain();
      if (burst == 0 && $urandom_range(0, 39) == 0) burst = $urandom_range(DEPTH - 4, DEPTH + 3);
      pick_item(burst > 0, k, f, rec);
      if (burst > 0) burst--;
      issue(k, f, rec, 1'b0, '0);
      sent++;
    end

    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS frame_indexed_jitter_buffer");
    end else begin
      $display("FAIL frame_indexed_jitter_buffer");
    end
    $finish;
  end

endmodule
